[rtl/lik_pkg.sv]
package lik_pkg;

   localparam int POSITION_WIDTH = 20;
   localparam int CORDIC_STAGES  = 18;
   localparam int LENGTH_WIDTH   = POSITION_WIDTH - 1;
   localparam int ANGLE_WIDTH    = 20;

   // CORDIC datapath
   localparam int CIN_W = 32;
   localparam int CX_W  = 34;
   localparam int CZ_W  = 34;
   localparam int IDX_W = 5;

   // square root datapath, one result bit per cell
   localparam int SQ_IN_W  = 64;
   localparam int SQ_CELLS = 32;
   localparam int SQ_OUT_W = 33;

   // leg plane geometry after range normalization
   localparam int NORM_BITS = 29;
   localparam int MW   = POSITION_WIDTH + 1;
   localparam int SH_W = $clog2(MW + 1);
   localparam int NW   = (MW < NORM_BITS) ? MW : NORM_BITS;
   localparam int DW   = NW + 1;
   localparam int SQW  = 2 * NW;
   localparam int D2W  = 2 * NW + 1;
   localparam int NUMW = 2 * NW + 3;
   localparam int DENW = 2 * NW + 2;
   localparam int ACW  = 30;
   localparam int KW   = $clog2(DENW + 1);

   localparam int QW        = CZ_W + 2;
   localparam int Q16_SHIFT = 14;

   // pipeline timing
   localparam int LAT_CORDIC = CORDIC_STAGES + 1;
   localparam int LAT_SQRT   = SQ_CELLS + 1;
   localparam int LAT_ACOS   = 5 + LAT_SQRT + LAT_CORDIC;
   localparam int T_FINAL    = 8 + 2 * LAT_SQRT + LAT_ACOS;
   localparam int D_FZ       = 2 + LAT_SQRT;
   localparam int D_ROT      = T_FINAL - LAT_CORDIC;
   localparam int D_ALPHA    = T_FINAL - 5 - LAT_SQRT - LAT_CORDIC;
   localparam int D_SIDE     = LAT_SQRT;
   localparam int D_UNR      = LAT_ACOS;

   localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      CSR_HIP_OFFSET_X,
      CSR_HIP_OFFSET_Y,
      CSR_HIP_OFFSET_Z,
      CSR_THIGH_LENGTH,
      CSR_SHANK_LENGTH
   } csr_index_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [SQ_IN_W-1:0] rem;
      logic [SQ_IN_W-1:0] res;
   } sqrt_type;

endpackage

[rtl/leg_inverse_kinematics_3dof.sv]
// Three-joint leg inverse kinematics (hip yaw, hip pitch, knee).
//
// Request channel (req_valid/req_ready): foot position in the body frame,
// Q.16 metres, plus a leg index. Response channel (rsp_valid/rsp_ready):
// yaw, pitch and knee angles in Q.16 radians and an unreachable flag.
// Every request transaction yields exactly one response transaction, in order.
//
// Throughput: one transaction per cycle while the chain is not frozen.
// The pipeline depth is set by three square roots in series (reach,
// distance, law of cosines; each 32 cells plus a rounding register), the
// CORDIC chains of the law-of-cosines unit and the glue stages.
//
// Stall: the response register holds until taken; the pipeline keeps
// shifting (and req_ready stays high) as long as the stage in front of the
// response register is empty. Only when a finished result is also waiting
// behind a held response does the whole chain freeze and req_ready drop.
//
// Reset (synchronous, active high) empties the pipeline and loads the
// registers with their defaults (offsets 0, segment lengths 13107). The
// user writes registers via the csr_ port only when idle (not enforced).
module leg_inverse_kinematics_3dof (
   input  logic                                        clock,
   input  logic                                        reset,

   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [lik_pkg::POSITION_WIDTH-1:0]   req_foot_x,
   input  logic signed [lik_pkg::POSITION_WIDTH-1:0]   req_foot_y,
   input  logic signed [lik_pkg::POSITION_WIDTH-1:0]   req_foot_z,
   input  logic [1:0]                                  req_leg_index,

   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [lik_pkg::ANGLE_WIDTH-1:0]      rsp_yaw_angle,
   output logic signed [lik_pkg::ANGLE_WIDTH-1:0]      rsp_pitch_angle,
   output logic signed [lik_pkg::ANGLE_WIDTH-1:0]      rsp_knee_angle,
   output logic                                        rsp_unreachable,

   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [lik_pkg::CSR_ADDR_W-1:0]              csr_paddr,
   input  logic [31:0]                                 csr_pwdata,
   output logic [31:0]                                 csr_prdata,
   output logic                                        csr_pready
);
   import lik_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int LW = LENGTH_WIDTH;

   typedef struct packed {
      logic [D2W-1:0] d2;
      logic [NW-1:0]  l1s;
      logic [NW-1:0]  l2s;
      logic [SQW-1:0] l1sq;
      logic [SQW-1:0] l2sq;
   } geometry_type;

   function automatic logic [ANGLE_WIDTH-1:0] to_q16(input logic signed [QW-1:0] v);
      logic [QW-1:0] m;
      logic [QW-1:0] q;
      m = (v < 0) ? QW'(-v) : QW'(v);
      q = (m + (QW'(1) << (Q16_SHIFT - 1))) >> Q16_SHIFT;
      return (v < 0) ? ANGLE_WIDTH'(-q) : ANGLE_WIDTH'(q);
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [PW-1:0] hip_x_ff, hip_y_ff, hip_z_ff;
   logic [LW-1:0] thigh_ff, shank_ff;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hip_x_ff <= '0;
         hip_y_ff <= '0;
         hip_z_ff <= '0;
         thigh_ff <= LW'(13107);
         shank_ff <= LW'(13107);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
            CSR_HIP_OFFSET_X: hip_x_ff <= csr_pwdata[PW-1:0];
            CSR_HIP_OFFSET_Y: hip_y_ff <= csr_pwdata[PW-1:0];
            CSR_HIP_OFFSET_Z: hip_z_ff <= csr_pwdata[PW-1:0];
            CSR_THIGH_LENGTH: thigh_ff <= csr_pwdata[LW-1:0];
            CSR_SHANK_LENGTH: shank_ff <= csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
         CSR_HIP_OFFSET_X: csr_prdata = 32'($unsigned(hip_x_ff));
         CSR_HIP_OFFSET_Y: csr_prdata = 32'($unsigned(hip_y_ff));
         CSR_HIP_OFFSET_Z: csr_prdata = 32'($unsigned(hip_z_ff));
         CSR_THIGH_LENGTH: csr_prdata = 32'(thigh_ff);
         CSR_SHANK_LENGTH: csr_prdata = 32'(shank_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   // one shared advance for every stage; bubbles in front of the response
   // register let the chain move while a response is held
   logic advance;
   logic vld_ff [0:T_FINAL];
   logic rsp_valid_ff;

   assign advance   = rsp_ready || !rsp_valid_ff || !vld_ff[T_FINAL];
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= T_FINAL; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= T_FINAL; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // ---------------- input stage ----------------
   logic signed [PW-1:0] foot_x_ff, foot_y_ff, foot_z_ff;
   logic [1:0] leg_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         foot_x_ff <= req_foot_x;
         foot_y_ff <= req_foot_y;
         foot_z_ff <= req_foot_z;
         leg_ff    <= req_leg_index;
      end
   end

   // yaw: atan2(y, x) on the raw foot position
   logic signed [CZ_W-1:0] rot_angle;

   lik_atan2 u_yaw (
      .clock   (clock),
      .advance (advance),
      .y_value (CIN_W'(foot_y_ff)),
      .x_value (CIN_W'(foot_x_ff)),
      .angle   (rot_angle)
   );

   // ---------------- horizontal reach ----------------
   logic [PW-1:0] ax, ay;
   logic [2*PW-1:0] sqx_ff, sqy_ff;
   logic [SQ_IN_W-1:0] reach_sq_ff;
   logic [SQ_OUT_W-1:0] reach_root;

   assign ax = foot_x_ff[PW-1] ? PW'(-foot_x_ff) : PW'(foot_x_ff);
   assign ay = foot_y_ff[PW-1] ? PW'(-foot_y_ff) : PW'(foot_y_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff      <= ax * ax;
         sqy_ff      <= ay * ay;
         reach_sq_ff <= SQ_IN_W'(sqx_ff) + SQ_IN_W'(sqy_ff);
      end
   end

   lik_isqrt u_reach (
      .clock   (clock),
      .advance (advance),
      .value   (reach_sq_ff),
      .root    (reach_root)
   );

   // ---------------- side data delay lines ----------------
   logic signed [PW-1:0] fz_line_ff [0:D_FZ-1];
   logic signed [CZ_W-1:0] rot_line_ff [0:D_ROT-1];
   logic [1:0] leg_line_ff [0:T_FINAL-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         fz_line_ff[0]  <= foot_z_ff;
         rot_line_ff[0] <= rot_angle;
         leg_line_ff[0] <= leg_ff;
         for (int i = 1; i < D_FZ; i++) begin
            fz_line_ff[i] <= fz_line_ff[i-1];
         end
         for (int i = 1; i < D_ROT; i++) begin
            rot_line_ff[i] <= rot_line_ff[i-1];
         end
         for (int i = 1; i < T_FINAL; i++) begin
            leg_line_ff[i] <= leg_line_ff[i-1];
         end
      end
   end

   // ---------------- leg plane: offsets and normalization ----------------
   logic signed [PW+1:0] a_ff;
   logic signed [PW:0] c_ff;
   logic [MW-1:0] ua_in, uc_in, m_max, ua_ff, uc_ff;
   logic cneg_ff;
   logic [SH_W-1:0] sh_in, sh_ff;
   logic [NW-1:0] as_ff, csm_ff, l1s_ff, l2s_ff, csm_in;
   logic signed [NW:0] cs_ff;

   always_comb begin
      ua_in = (a_ff < 0) ? MW'(-a_ff) : MW'(a_ff);
      uc_in = (c_ff < 0) ? MW'(-c_ff) : MW'(c_ff);
      m_max = ua_in;
      if (uc_in > m_max) begin
         m_max = uc_in;
      end
      if (MW'(thigh_ff) > m_max) begin
         m_max = MW'(thigh_ff);
      end
      if (MW'(shank_ff) > m_max) begin
         m_max = MW'(shank_ff);
      end
      // common right shift that brings every magnitude below 2^29
      sh_in = '0;
      for (int j = NORM_BITS; j < MW; j++) begin
         if (m_max[j]) begin
            sh_in = SH_W'(j - NORM_BITS + 1);
         end
      end
      csm_in = NW'(uc_ff >> sh_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff    <= $signed({1'b0, reach_root[PW:0]}) - (PW+2)'(hip_x_ff);
         c_ff    <= (PW+1)'(fz_line_ff[D_FZ-1]) - (PW+1)'(hip_z_ff);

         ua_ff   <= ua_in;
         uc_ff   <= uc_in;
         cneg_ff <= c_ff < 0;
         sh_ff   <= sh_in;

         as_ff   <= NW'(ua_ff >> sh_ff);
         csm_ff  <= csm_in;
         cs_ff   <= cneg_ff ? -$signed({1'b0, csm_in}) : $signed({1'b0, csm_in});
         l1s_ff  <= NW'(MW'(thigh_ff) >> sh_ff);
         l2s_ff  <= NW'(MW'(shank_ff) >> sh_ff);
      end
   end

   // alpha: elevation of the foot seen from the pitch joint
   logic signed [CZ_W-1:0] alpha_angle;
   logic signed [CZ_W-1:0] alpha_line_ff [0:D_ALPHA-1];

   lik_atan2 u_alpha (
      .clock   (clock),
      .advance (advance),
      .y_value (CIN_W'(cs_ff)),
      .x_value (CIN_W'($signed({1'b0, as_ff}))),
      .angle   (alpha_angle)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_line_ff[0] <= alpha_angle;
         for (int i = 1; i < D_ALPHA; i++) begin
            alpha_line_ff[i] <= alpha_line_ff[i-1];
         end
      end
   end

   // ---------------- squared distances ----------------
   logic [SQW-1:0] as2_ff, cs2_ff, l1sq_ff, l2sq_ff;
   logic [NW-1:0] l1d_ff, l2d_ff;
   geometry_type geo_ff;
   geometry_type side_line_ff [0:D_SIDE-1];
   geometry_type side;

   always_ff @(posedge clock) begin
      if (advance) begin
         as2_ff  <= as_ff * as_ff;
         cs2_ff  <= csm_ff * csm_ff;
         l1sq_ff <= l1s_ff * l1s_ff;
         l2sq_ff <= l2s_ff * l2s_ff;
         l1d_ff  <= l1s_ff;
         l2d_ff  <= l2s_ff;

         geo_ff.d2   <= D2W'(as2_ff) + D2W'(cs2_ff);
         geo_ff.l1s  <= l1d_ff;
         geo_ff.l2s  <= l2d_ff;
         geo_ff.l1sq <= l1sq_ff;
         geo_ff.l2sq <= l2sq_ff;

         side_line_ff[0] <= geo_ff;
         for (int i = 1; i < D_SIDE; i++) begin
            side_line_ff[i] <= side_line_ff[i-1];
         end
      end
   end

   logic [SQ_OUT_W-1:0] dist_root;

   lik_isqrt u_dist (
      .clock   (clock),
      .advance (advance),
      .value   (SQ_IN_W'(geo_ff.d2)),
      .root    (dist_root)
   );

   // ---------------- law of cosines operands ----------------
   logic [DW-1:0] dist_len;
   logic [NW+DW-1:0] prod_b;
   logic [SQW-1:0] prod_g;
   logic signed [NUMW-1:0] num_b_ff, num_g_ff;
   logic [DENW-1:0] den_b_ff, den_g_ff;
   logic unr0_ff;
   logic unr_line_ff [0:D_UNR-1];

   always_comb begin
      side     = side_line_ff[D_SIDE-1];
      dist_len = DW'(dist_root);
      prod_b   = side.l1s * dist_len;
      prod_g   = side.l1s * side.l2s;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_b_ff <= $signed(NUMW'(side.l1sq) + NUMW'(side.d2) - NUMW'(side.l2sq));
         num_g_ff <= $signed(NUMW'(side.l1sq) + NUMW'(side.l2sq) - NUMW'(side.d2));
         den_b_ff <= DENW'({prod_b, 1'b0});
         den_g_ff <= DENW'({prod_g, 1'b0});
         // zero distance
         unr0_ff  <= side.d2 == '0;

         unr_line_ff[0] <= unr0_ff;
         for (int i = 1; i < D_UNR; i++) begin
            unr_line_ff[i] <= unr_line_ff[i-1];
         end
      end
   end

   logic signed [CZ_W-1:0] beta_angle, gamma_angle;
   logic beta_clamped, gamma_clamped;

   lik_acos u_beta (
      .clock   (clock),
      .advance (advance),
      .num     (num_b_ff),
      .den     (den_b_ff),
      .angle   (beta_angle),
      .clamped (beta_clamped)
   );

   lik_acos u_gamma (
      .clock   (clock),
      .advance (advance),
      .num     (num_g_ff),
      .den     (den_g_ff),
      .angle   (gamma_angle),
      .clamped (gamma_clamped)
   );

   // ---------------- joint angles and response register ----------------
   logic mirror;
   logic [1:0] leg_last;
   logic signed [QW-1:0] rot_q, alpha_q, beta_q, gamma_q, ab_q;
   logic signed [QW-1:0] yaw_q, pitch_q, knee_q;
   logic [ANGLE_WIDTH-1:0] yaw_ff, pitch_ff, knee_ff;
   logic unreach_ff;

   always_comb begin
      leg_last = leg_line_ff[T_FINAL-1];
      // left front and right hind share one sign convention
      mirror   = (leg_last == 2'd0) || (leg_last == 2'd3);
      rot_q    = QW'(rot_line_ff[D_ROT-1]);
      alpha_q  = QW'(alpha_line_ff[D_ALPHA-1]);
      beta_q   = QW'(beta_angle);
      gamma_q  = QW'(gamma_angle);
      ab_q     = alpha_q + beta_q;
      yaw_q    = mirror ? QW'(HALF_PI_Q30) - rot_q : rot_q;
      pitch_q  = (mirror ? ab_q : -ab_q) + QW'(HALF_PI_Q30);
      knee_q   = mirror ? gamma_q : QW'(PI_Q30) - gamma_q;
   end

   always_ff @(posedge clock) begin
      if (vld_ff[T_FINAL] && advance) begin
         yaw_ff     <= to_q16(yaw_q);
         pitch_ff   <= to_q16(pitch_q);
         knee_ff    <= to_q16(knee_q);
         unreach_ff <= unr_line_ff[D_UNR-1] || beta_clamped || gamma_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (vld_ff[T_FINAL] && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_knee_angle  = knee_ff;
   assign rsp_unreachable = unreach_ff;

endmodule

[rtl/lik_cordic_cell.sv]
module lik_cordic_cell (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [lik_pkg::IDX_W-1:0]   stage_index,
   input  lik_pkg::cordic_type         upstream,
   output lik_pkg::cordic_type         downstream
);
   import lik_pkg::*;

   cordic_type stage_in, stage_ff;
   logic signed [CX_W-1:0] dx, dy;
   logic signed [CZ_W-1:0] step_angle;

   always_comb begin
      dx         = upstream.y >>> stage_index;
      dy         = upstream.x >>> stage_index;
      step_angle = $signed({{(CZ_W-32){1'b0}}, ATAN_TAB[stage_index]});
      stage_in   = upstream;
      // no rotation once y is exactly zero
      if (upstream.y > 0) begin
         stage_in.x = upstream.x + dx;
         stage_in.y = upstream.y - dy;
         stage_in.z = upstream.z + step_angle;
      end else if (upstream.y < 0) begin
         stage_in.x = upstream.x - dx;
         stage_in.y = upstream.y + dy;
         stage_in.z = upstream.z - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign downstream = stage_ff;

endmodule

[rtl/lik_atan2.sv]
module lik_atan2 (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [lik_pkg::CIN_W-1:0]  y_value,
   input  logic signed [lik_pkg::CIN_W-1:0]  x_value,
   output logic signed [lik_pkg::CZ_W-1:0]   angle
);
   import lik_pkg::*;

   cordic_type pre_in, pre_ff;
   cordic_type chain [0:CORDIC_STAGES];
   logic signed [CX_W-1:0] xe, ye;

   // fold the left half plane by a quarter turn
   always_comb begin
      xe       = CX_W'(x_value);
      ye       = CX_W'(y_value);
      pre_in.x = xe;
      pre_in.y = ye;
      pre_in.z = '0;
      if (xe < 0) begin
         if (ye >= 0) begin
            pre_in.x = ye;
            pre_in.y = -xe;
            pre_in.z = HALF_PI_Q30;
         end else begin
            pre_in.x = -ye;
            pre_in.y = xe;
            pre_in.z = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_ff <= pre_in;
      end
   end

   assign chain[0] = pre_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      lik_cordic_cell u_cell (
         .clock       (clock),
         .advance     (advance),
         .stage_index (IDX_W'(i)),
         .upstream    (chain[i]),
         .downstream  (chain[i+1])
      );
   end

   assign angle = chain[CORDIC_STAGES].z;

endmodule

[rtl/lik_sqrt_cell.sv]
module lik_sqrt_cell (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [lik_pkg::IDX_W-1:0]   stage_index,
   input  lik_pkg::sqrt_type           upstream,
   output lik_pkg::sqrt_type           downstream
);
   import lik_pkg::*;

   sqrt_type stage_in, stage_ff;
   logic [5:0] bit_pos;
   logic [SQ_IN_W-1:0] bit_value;
   logic [SQ_IN_W:0] trial;

   always_comb begin
      bit_pos   = 6'd62 - {stage_index, 1'b0};
      bit_value = SQ_IN_W'(1) << bit_pos;
      trial     = {1'b0, upstream.res} + {1'b0, bit_value};
      if ({1'b0, upstream.rem} >= trial) begin
         stage_in.rem = upstream.rem - trial[SQ_IN_W-1:0];
         stage_in.res = (upstream.res >> 1) + bit_value;
      end else begin
         stage_in.rem = upstream.rem;
         stage_in.res = upstream.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign downstream = stage_ff;

endmodule

[rtl/lik_isqrt.sv]
module lik_isqrt (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [lik_pkg::SQ_IN_W-1:0]    value,
   output logic [lik_pkg::SQ_OUT_W-1:0]   root
);
   import lik_pkg::*;

   sqrt_type chain [0:SQ_CELLS];
   sqrt_type last;
   logic [SQ_OUT_W-1:0] root_in, root_ff;

   assign chain[0].rem = value;
   assign chain[0].res = '0;

   for (genvar i = 0; i < SQ_CELLS; i++) begin : g_cell
      lik_sqrt_cell u_cell (
         .clock       (clock),
         .advance     (advance),
         .stage_index (IDX_W'(i)),
         .upstream    (chain[i]),
         .downstream  (chain[i+1])
      );
   end

   // round to nearest
   always_comb begin
      last    = chain[SQ_CELLS];
      root_in = SQ_OUT_W'(last.res) + SQ_OUT_W'(last.rem > last.res);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

[rtl/lik_acos.sv]
module lik_acos (
   input  logic                             clock,
   input  logic                             advance,
   input  logic signed [lik_pkg::NUMW-1:0]  num,
   input  logic [lik_pkg::DENW-1:0]         den,
   output logic signed [lik_pkg::CZ_W-1:0]  angle,
   output logic                             clamped
);
   import lik_pkg::*;

   logic signed [NUMW-1:0] den_s;
   logic flag_a_in, flag_a_ff, neg_a_ff;
   logic [DENW-1:0] den_a_ff;
   logic [NUMW-1:0] mag_a_in, mag_a_ff;
   logic [KW-1:0] k_a_in, k_a_ff;

   logic [ACW-1:0] ud_b_ff, un_b_ff;
   logic flag_b_ff, neg_b_ff;

   logic [2*ACW-1:0] udsq_ff, unsq_ff;
   logic [ACW-1:0] un_c_ff;
   logic flag_c_ff, neg_c_ff;

   logic [SQ_IN_W-1:0] diff_ff;
   logic signed [CIN_W-1:0] xs_d_ff;
   logic [1:0] mark_d_ff;

   logic signed [CIN_W-1:0] xs_line_ff [0:LAT_SQRT-1];
   logic [1:0] mark_line_ff [0:LAT_SQRT+LAT_CORDIC-1];

   logic [SQ_OUT_W-1:0] root;
   logic signed [CZ_W-1:0] cordic_angle;
   logic [1:0] mark_last;
   logic signed [CZ_W-1:0] angle_in, angle_ff;
   logic clamped_ff;

   // range check and normalizing shift
   always_comb begin
      den_s     = $signed({1'b0, den});
      flag_a_in = (den == '0) || (num > den_s) || (num < -den_s);
      mag_a_in  = (num < 0) ? NUMW'(-num) : NUMW'(num);
      k_a_in    = '0;
      for (int j = ACW; j < DENW; j++) begin
         if (den[j]) begin
            k_a_in = KW'(j - ACW + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flag_a_ff <= flag_a_in;
         neg_a_ff  <= num < 0;
         den_a_ff  <= den;
         mag_a_ff  <= mag_a_in;
         k_a_ff    <= k_a_in;

         ud_b_ff   <= ACW'(den_a_ff >> k_a_ff);
         un_b_ff   <= ACW'(mag_a_ff >> k_a_ff);
         flag_b_ff <= flag_a_ff;
         neg_b_ff  <= neg_a_ff;

         udsq_ff   <= ud_b_ff * ud_b_ff;
         unsq_ff   <= un_b_ff * un_b_ff;
         un_c_ff   <= un_b_ff;
         flag_c_ff <= flag_b_ff;
         neg_c_ff  <= neg_b_ff;

         diff_ff   <= SQ_IN_W'(udsq_ff - unsq_ff);
         xs_d_ff   <= neg_c_ff ? -$signed(CIN_W'(un_c_ff)) : $signed(CIN_W'(un_c_ff));
         mark_d_ff <= {flag_c_ff, neg_c_ff};

         xs_line_ff[0]   <= xs_d_ff;
         mark_line_ff[0] <= mark_d_ff;
         for (int i = 1; i < LAT_SQRT; i++) begin
            xs_line_ff[i] <= xs_line_ff[i-1];
         end
         for (int i = 1; i < LAT_SQRT + LAT_CORDIC; i++) begin
            mark_line_ff[i] <= mark_line_ff[i-1];
         end

         angle_ff   <= angle_in;
         clamped_ff <= mark_last[1];
      end
   end

   lik_isqrt u_root (
      .clock   (clock),
      .advance (advance),
      .value   (diff_ff),
      .root    (root)
   );

   lik_atan2 u_angle (
      .clock   (clock),
      .advance (advance),
      .y_value ($signed(CIN_W'(root))),
      .x_value (xs_line_ff[LAT_SQRT-1]),
      .angle   (cordic_angle)
   );

   // a clamped ratio gives zero above one and pi below minus one
   always_comb begin
      mark_last = mark_line_ff[LAT_SQRT+LAT_CORDIC-1];
      if (mark_last[1]) begin
         angle_in = mark_last[0] ? PI_Q30 : '0;
      end else begin
         angle_in = cordic_angle;
      end
   end

   assign angle   = angle_ff;
   assign clamped = clamped_ff;

endmodule
